// ===== rtl/rc5_pkg.sv =====
// Shared types, constants and helper functions for the RC5-16 decrypt block.
package rc5_pkg;

  localparam int ROUNDS      = 12;
  localparam int KEY_BYTES   = 16;
  localparam int TABLE_WORDS = 2 * (ROUNDS + 1);
  localparam int TABLE_ROWS  = ROUNDS + 1;
  localparam int KEY_WORDS   = (KEY_BYTES + 1) / 2;
  localparam int PASSES      = 3 * ((TABLE_WORDS > KEY_WORDS) ? TABLE_WORDS : KEY_WORDS);

  localparam int SK_IDX_W = $clog2(TABLE_WORDS);
  localparam int ROW_W    = $clog2(TABLE_ROWS);
  localparam int KW_IDX_W = $clog2(KEY_WORDS);
  localparam int PASS_W   = $clog2(PASSES);

  localparam logic [15:0] MAGIC_P = 16'hB7E1;
  localparam logic [15:0] MAGIC_Q = 16'h9E37;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_HIGH = 1'b1;

  typedef struct packed {
    logic        action;
    logic [15:0] cipher_first;
    logic [15:0] cipher_second;
  } rc5_in_t;

  typedef struct packed {
    logic [15:0] plain_first;
    logic [15:0] plain_second;
    logic        was_decrypt;
  } rc5_out_t;

  // controller to datapath commands
  typedef struct packed {
    logic                load;     // load key words, preset table, clear a/b
    logic                mix;      // one key schedule step
    logic                dec_cap;  // capture ciphertext pair
    logic                dec;      // one inverse round
    logic                fin_dec;  // final subtraction, write result
    logic                fin_exp;  // write expand-done result
    logic [SK_IDX_W-1:0] sk_idx;
    logic [KW_IDX_W-1:0] kw_idx;
    logic [ROW_W-1:0]    round;
  } rc5_cmd_t;

  // preset value of table word k: P + k*Q mod 2^16
  function automatic logic [15:0] preset_word(input int k);
    logic [31:0] v;
    v = 32'(MAGIC_P) + 32'(MAGIC_Q) * 32'(k);
    return v[15:0];
  endfunction

  function automatic logic [15:0] rotl16(input logic [15:0] x, input logic [3:0] s);
    logic [31:0] t;
    t = {x, x} << s;
    return t[31:16];
  endfunction

  function automatic logic [15:0] rotr16(input logic [15:0] x, input logic [3:0] s);
    logic [31:0] t;
    t = {x, x} >> s;
    return t[15:0];
  endfunction

endpackage

// ===== rtl/rc5_16bit_block_decrypt.sv =====
// Decrypt: one inverse round per cycle over 12 rounds, then a final subtraction in ST_FIN,
// which registers the strobe (done_o); busy stays high until the strobe, so items do not overlap.
// Expand: 78 key schedule steps at one step per cycle; the last step registers the strobe.
// busy is low again in the strobe cycle, so the next item may start there.
// Reset (rst_ni low, asynchronous) clears key registers, the subkey table and the sequencer.
// The result strobe lasts one cycle and the receiver cannot stall it.
module rc5_16bit_block_decrypt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command channel
  input  logic                          start,
  output logic                          busy,
  input  rc5_pkg::rc5_in_t              in_i,
  // result channel
  output logic                          done_o,
  output rc5_pkg::rc5_out_t             res_o,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rc5_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [63:0]                   cfg_data_i
);

  rc5_pkg::rc5_cmd_t cmd;

  // config writes are taken any time; they only touch the key registers
  assign cfg_ready_o = 1'b1;

  rc5_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .action_i (in_i.action),
    .busy_o   (busy),
    .done_o   (done_o),
    .cmd_o    (cmd)
  );

  rc5_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_i        (in_i),
    .cmd_i       (cmd),
    .res_o       (res_o)
  );

endmodule

// ===== rtl/rc5_ctrl.sv =====
// Sequencer for key expansion and block decryption.
module rc5_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              action_i,
  output logic              busy_o,
  output logic              done_o,
  output rc5_pkg::rc5_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MIX,
    ST_DEC,
    ST_FIN
  } state_e;

  state_e                       state_q;
  logic [rc5_pkg::SK_IDX_W-1:0] sk_q;
  logic [rc5_pkg::KW_IDX_W-1:0] kw_q;
  logic [rc5_pkg::PASS_W-1:0]   pass_q;
  logic [rc5_pkg::ROW_W-1:0]    rnd_q;
  logic                         done_q;
  logic                         accept;
  logic                         last_pass;

  assign busy_o    = (state_q != ST_IDLE);
  assign accept    = start_i && !busy_o;
  assign last_pass = (pass_q == rc5_pkg::PASS_W'(rc5_pkg::PASSES - 1));
  assign done_o    = done_q;

  always_comb begin
    cmd_o         = '0;
    cmd_o.sk_idx  = sk_q;
    cmd_o.kw_idx  = kw_q;
    cmd_o.round   = rnd_q;
    cmd_o.load    = accept && !action_i;
    cmd_o.dec_cap = accept && action_i;
    cmd_o.mix     = (state_q == ST_MIX);
    cmd_o.fin_exp = (state_q == ST_MIX) && last_pass;
    cmd_o.dec     = (state_q == ST_DEC);
    cmd_o.fin_dec = (state_q == ST_FIN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sk_q    <= '0;
      kw_q    <= '0;
      pass_q  <= '0;
      rnd_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            sk_q   <= '0;
            kw_q   <= '0;
            pass_q <= '0;
            rnd_q  <= rc5_pkg::ROW_W'(rc5_pkg::ROUNDS);
            state_q <= action_i ? ST_DEC : ST_MIX;
          end
        end
        ST_MIX: begin
          sk_q   <= (sk_q == rc5_pkg::SK_IDX_W'(rc5_pkg::TABLE_WORDS - 1)) ? '0 : sk_q + 1'b1;
          kw_q   <= (kw_q == rc5_pkg::KW_IDX_W'(rc5_pkg::KEY_WORDS - 1)) ? '0 : kw_q + 1'b1;
          pass_q <= pass_q + 1'b1;
          if (last_pass) begin
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        ST_DEC: begin
          rnd_q <= rnd_q - 1'b1;
          if (rnd_q == rc5_pkg::ROW_W'(1)) begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/rc5_dpath.sv =====
// Key registers, subkey table, key word scratch and the round/mix datapath.
module rc5_dpath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rc5_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [63:0]                     cfg_data_i,
  input  rc5_pkg::rc5_in_t                in_i,
  input  rc5_pkg::rc5_cmd_t               cmd_i,
  output rc5_pkg::rc5_out_t               res_o
);

  logic [63:0] key_lo_q;
  logic [63:0] key_hi_q;
  // row k holds {S[2k+1], S[2k]}
  logic [31:0] tbl_q [rc5_pkg::TABLE_ROWS];
  logic [15:0] kw_q  [rc5_pkg::KEY_WORDS];
  logic [15:0] a_q, b_q;
  rc5_pkg::rc5_out_t res_q;

  logic [127:0]              key_all;
  logic [rc5_pkg::ROW_W-1:0] rd_row;
  logic [31:0]               row;
  logic [15:0]               sk_word;
  logic [15:0]               mix_a, mix_b, mix_ab;
  logic [15:0]               dec_a, dec_b;

  assign key_all = {key_hi_q, key_lo_q};

  always_comb begin
    rd_row = cmd_i.round;
    if (cmd_i.mix) begin
      rd_row = cmd_i.sk_idx[rc5_pkg::SK_IDX_W-1:1];
    end else if (cmd_i.fin_dec) begin
      rd_row = '0;
    end
  end

  assign row     = tbl_q[rd_row];
  assign sk_word = cmd_i.sk_idx[0] ? row[31:16] : row[15:0];

  // key schedule step
  assign mix_a  = rc5_pkg::rotl16(sk_word + a_q + b_q, 4'd3);
  assign mix_ab = mix_a + b_q;
  assign mix_b  = rc5_pkg::rotl16(kw_q[cmd_i.kw_idx] + mix_ab, mix_ab[3:0]);

  // inverse round
  assign dec_b = rc5_pkg::rotr16(b_q - row[31:16], a_q[3:0]) ^ a_q;
  assign dec_a = rc5_pkg::rotr16(a_q - row[15:0], dec_b[3:0]) ^ dec_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_lo_q <= '0;
      key_hi_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        rc5_pkg::CFG_KEY_LOW:  key_lo_q <= cfg_data_i;
        rc5_pkg::CFG_KEY_HIGH: key_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < rc5_pkg::TABLE_ROWS; k++) begin
        tbl_q[k] <= '0;
      end
    end else if (cmd_i.load) begin
      for (int k = 0; k < rc5_pkg::TABLE_ROWS; k++) begin
        tbl_q[k] <= {rc5_pkg::preset_word(2 * k + 1), rc5_pkg::preset_word(2 * k)};
      end
    end else if (cmd_i.mix) begin
      if (cmd_i.sk_idx[0]) begin
        tbl_q[rd_row][31:16] <= mix_a;
      end else begin
        tbl_q[rd_row][15:0] <= mix_a;
      end
    end
  end

  // scratch is always loaded before it is read
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int n = 0; n < rc5_pkg::KEY_WORDS; n++) begin
        kw_q[n] <= key_all[16*n +: 16];
      end
    end else if (cmd_i.mix) begin
      kw_q[cmd_i.kw_idx] <= mix_b;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      a_q <= '0;
      b_q <= '0;
    end else if (cmd_i.dec_cap) begin
      a_q <= in_i.cipher_first;
      b_q <= in_i.cipher_second;
    end else if (cmd_i.mix) begin
      a_q <= mix_a;
      b_q <= mix_b;
    end else if (cmd_i.dec) begin
      a_q <= dec_a;
      b_q <= dec_b;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin_exp) begin
      res_q <= '0;
    end else if (cmd_i.fin_dec) begin
      res_q.plain_first  <= a_q - row[15:0];
      res_q.plain_second <= b_q - row[31:16];
      res_q.was_decrypt  <= 1'b1;
    end
  end

  assign res_o = res_q;

endmodule
